// File: design/pgmfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pgmfd_pkg;

    localparam int MAX_FRAME_SAMPLES = 64;
    localparam int NUM_INPUT_LANES   = 4;
    localparam int ADDR_W            = $clog2(MAX_FRAME_SAMPLES);
    localparam int FILL_W            = ADDR_W + 1;
    localparam int LANE_W            = 3;
    localparam int SAMPLE_W          = 16;
    localparam int GAIN_W            = 16;
    localparam int STAMP_W           = 32;
    localparam int AGE_W             = 16;
    localparam int PROD_W            = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W             = PROD_W + 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_INDEX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_0       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_3       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 3'd6;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISSING  = 3'd1,
        ST_STALE    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_TOO_LONG = 3'd4
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_RANGE  = 7'b0001000,
        S_STORE  = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_DUMP   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic missing;
        logic stale;
    } t_lane_chk;

endpackage
`default_nettype wire

// File: design/pcm16_gain_mixer_frame_drop.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+---------------------------
// item in   | i_sample_0..3, i_stamp_0..3, i_present_mask,      | taken when i_start && !o_busy
//           | i_last_sample                                     |
// result    | o_mixed_sample, o_status, o_last                  | o_strobe, one cycle each
// config    | i_cfg_idx, i_cfg_data                             | written when i_cfg_we
//
// With N active inputs o_busy stays high from the accepting edge while the single shared
// multiplier serves the inputs in turn, a multiply and an accumulate state each; one more
// multiply state closes the lanes, then range check, store and finish follow. A lane fault
// at input k ends this at that input, and an item of an already faulted frame goes straight
// to finish. A clean last item then holds o_busy while the buffered samples are dumped;
// each result shows in the cycle after its dump state, the final one in the first idle cycle.
// Reset is synchronous and active low; the frame buffer is not cleared.
// Results cannot be held off: each one is shown for exactly one cycle.
module pcm16_gain_mixer_frame_drop
    import pgmfd_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_0,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_1,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_2,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_3,
    input  wire logic [STAMP_W-1:0]      i_stamp_0,
    input  wire logic [STAMP_W-1:0]      i_stamp_1,
    input  wire logic [STAMP_W-1:0]      i_stamp_2,
    input  wire logic [STAMP_W-1:0]      i_stamp_3,
    input  wire logic [3:0]              i_present_mask,
    input  wire                          i_last_sample,
    input  wire                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                         o_strobe,
    output logic signed [SAMPLE_W-1:0]   o_mixed_sample,
    output logic [2:0]                   o_status,
    output logic                         o_last
);

    // Configuration.
    logic [2:0]        r_num_inputs;
    logic [1:0]        r_master;
    logic [GAIN_W-1:0] r_gain [NUM_INPUT_LANES];
    logic [AGE_W-1:0]  r_max_age;

    // Control.
    t_state            r_state;
    logic [LANE_W-1:0] r_lane;
    t_status           r_fault;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic              r_strobe;

    // Item payload.
    logic signed [SAMPLE_W-1:0] r_sample [NUM_INPUT_LANES];
    logic [STAMP_W-1:0]         r_stamp  [NUM_INPUT_LANES];
    logic [STAMP_W-1:0]         r_ref_stamp;
    logic [3:0]                 r_present;
    logic                       r_last_in;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    t_status                    r_out_status;
    logic                       r_out_last;

    // Frame buffer.
    logic [SAMPLE_W-1:0] r_mem [MAX_FRAME_SAMPLES];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic                     accept;
    logic [LANE_W-1:0]        n_active;
    logic [STAMP_W-1:0]       ref_sel;
    logic                     lane_en;
    logic signed [PROD_W-1:0] lane_prod;
    t_lane_chk                lane_chk;
    logic                     in_range;
    logic [ACC_W-1:0]         neg_mag;
    logic [ACC_W-1:0]         neg_rnd;
    logic [ACC_W+15-1:0]      pos_full;
    logic [SAMPLE_W-1:0]      enc;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     dump_end;

    assign o_busy         = (r_state != S_IDLE);
    assign accept         = i_start && (r_state == S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_mixed_sample = r_out_sample;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

    always_comb begin
        if (r_num_inputs == 3'd0) begin
            n_active = 3'd1;
        end else if (r_num_inputs > LANE_W'(NUM_INPUT_LANES)) begin
            n_active = LANE_W'(NUM_INPUT_LANES);
        end else begin
            n_active = r_num_inputs;
        end
    end

    always_comb begin
        case (r_master)
            2'd0:    ref_sel = i_stamp_0;
            2'd1:    ref_sel = i_stamp_1;
            2'd2:    ref_sel = i_stamp_2;
            default: ref_sel = i_stamp_3;
        endcase
    end

    assign lane_en = (r_state == S_MUL) && (r_lane != n_active);

    pgmfd_lane u_lane (
        .i_clk       (i_clk),
        .i_en        (lane_en),
        .i_sample    (r_sample[r_lane[1:0]]),
        .i_gain      (r_gain[r_lane[1:0]]),
        .i_ref_stamp (r_ref_stamp),
        .i_stamp     (r_stamp[r_lane[1:0]]),
        .i_present   (r_present[r_lane[1:0]]),
        .i_is_master (r_lane[1:0] == r_master),
        .i_max_age   (r_max_age),
        .o_prod      (lane_prod),
        .o_chk       (lane_chk)
    );

    // The sum is Q27: one full scale is 2^27.
    assign in_range = (r_acc >= -(ACC_W'(1) <<< 27)) && (r_acc <= (ACC_W'(1) <<< 27));

    // Negative sums scale by 32768, positive ones by 32767; both round half away from zero.
    always_comb begin
        neg_mag  = -r_acc;
        neg_rnd  = (neg_mag + ACC_W'(2048)) >> 12;
        pos_full = ({15'b0, r_acc} << 15) - {15'b0, r_acc} + ((ACC_W+15)'(1) << 26);
        if (r_acc[ACC_W-1]) begin
            enc = -neg_rnd[SAMPLE_W-1:0];
        end else begin
            enc = pos_full[27+SAMPLE_W-1:27];
        end
    end

    assign rd_addr  = (r_state == S_FINISH) ? '0 : ADDR_W'(r_idx + FILL_W'(1));
    assign dump_end = ((r_idx + FILL_W'(1)) == r_fill);

    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) begin
            r_mem[r_fill[ADDR_W-1:0]] <= enc;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_inputs <= 3'd1;
            r_master     <= 2'd0;
            for (int i = 0; i < NUM_INPUT_LANES; i++) begin
                r_gain[i] <= GAIN_W'(4096);
            end
            r_max_age    <= AGE_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_INPUTS:   r_num_inputs <= i_cfg_data[2:0];
                CFG_MASTER_INDEX: r_master     <= i_cfg_data[1:0];
                CFG_GAIN_0:       r_gain[0]    <= i_cfg_data;
                CFG_GAIN_1:       r_gain[1]    <= i_cfg_data;
                CFG_GAIN_2:       r_gain[2]    <= i_cfg_data;
                CFG_GAIN_3:       r_gain[3]    <= i_cfg_data;
                CFG_MAX_AGE:      r_max_age    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lane   <= '0;
            r_fault  <= ST_OK;
            r_fill   <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_DUMP) ||
                        ((r_state == S_FINISH) && r_last_in && (r_fault != ST_OK));
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_lane  <= '0;
                        // Once a frame has faulted, its later items are not examined.
                        r_state <= (r_fault == ST_OK) ? S_MUL : S_FINISH;
                    end
                end
                S_MUL: begin
                    r_state <= (r_lane == n_active) ? S_RANGE : S_ACC;
                end
                S_ACC: begin
                    if (lane_chk.missing) begin
                        r_fault <= ST_MISSING;
                        r_state <= S_FINISH;
                    end else if (lane_chk.stale) begin
                        r_fault <= ST_STALE;
                        r_state <= S_FINISH;
                    end else begin
                        r_lane  <= r_lane + LANE_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_RANGE: begin
                    if (!in_range) begin
                        r_fault <= ST_RANGE;
                        r_state <= S_FINISH;
                    end else if (r_fill >= FILL_W'(MAX_FRAME_SAMPLES)) begin
                        r_fault <= ST_TOO_LONG;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_fill  <= r_fill + FILL_W'(1);
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_last_in) begin
                        r_state <= S_IDLE;
                    end else if (r_fault != ST_OK) begin
                        r_fault  <= ST_OK;
                        r_fill   <= '0;
                        r_state  <= S_IDLE;
                    end else if (r_fill == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_DUMP;
                    end
                end
                S_DUMP: begin
                    r_idx    <= r_idx + FILL_W'(1);
                    if (dump_end) begin
                        r_fill  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample[0] <= i_sample_0;
            r_sample[1] <= i_sample_1;
            r_sample[2] <= i_sample_2;
            r_sample[3] <= i_sample_3;
            r_stamp[0]  <= i_stamp_0;
            r_stamp[1]  <= i_stamp_1;
            r_stamp[2]  <= i_stamp_2;
            r_stamp[3]  <= i_stamp_3;
            r_ref_stamp <= ref_sel;
            r_present   <= i_present_mask;
            r_last_in   <= i_last_sample;
            r_acc       <= '0;
        end else if ((r_state == S_ACC) && !lane_chk.missing && !lane_chk.stale) begin
            r_acc <= r_acc + ACC_W'(lane_prod);
        end

        if ((r_state == S_FINISH) && r_last_in && (r_fault != ST_OK)) begin
            r_out_sample <= '0;
            r_out_status <= r_fault;
            r_out_last   <= 1'b1;
        end else if (r_state == S_DUMP) begin
            r_out_sample <= r_rd_data;
            r_out_status <= ST_OK;
            r_out_last   <= dump_end;
        end
    end

endmodule
`default_nettype wire

// File: design/pgmfd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module pgmfd_lane
    import pgmfd_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [GAIN_W-1:0]     i_gain,
    input  wire logic [STAMP_W-1:0]    i_ref_stamp,
    input  wire logic [STAMP_W-1:0]    i_stamp,
    input  wire                        i_present,
    input  wire                        i_is_master,
    input  wire logic [AGE_W-1:0]      i_max_age,
    output logic signed [PROD_W-1:0]   o_prod,
    output t_lane_chk                  o_chk
);

    logic signed [PROD_W-1:0] prod;
    logic [STAMP_W:0]         age;
    t_lane_chk                chk;

    always_comb begin
        prod = i_sample * $signed({1'b0, i_gain});
        // The age is a signed difference; its top bit flags a frame from the future.
        age  = {1'b0, i_ref_stamp} - {1'b0, i_stamp};
        chk.missing = !i_is_master && !i_present;
        chk.stale   = !i_is_master &&
                      (age[STAMP_W] || (age[STAMP_W-1:0] > {{(STAMP_W-AGE_W){1'b0}}, i_max_age}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod <= prod;
            o_chk  <= chk;
        end
    end

endmodule
`default_nettype wire
